/* rtl/fcu_pkg.sv */
// ----------------------------------------------------------------------------
// FIR full convolution package
// Shared word types, field widths, codes and control structs for the FIR
// full convolution unit and its cells, sequencer and adder tree.
// ----------------------------------------------------------------------------
package fcu_pkg;

   // Field widths of the request and response words.
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int FILT_W      = 38;
   localparam int TAP_COUNT_W = 7;
   localparam int TAP_INDEX_W = 6;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index of the tap count register (paddr bit 2).
   localparam logic REG_TAP_COUNT = 1'b0;

   // Request operation codes.
   typedef enum logic {
      OP_COEF   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // Request word.
   typedef struct packed {
      op_type                    op;
      logic [TAP_INDEX_W-1:0]    tap_index;
      logic signed [COEF_W-1:0]  coef_value;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic                      last_sample;
   } req_type;

   // Response word.
   typedef struct packed {
      logic signed [FILT_W-1:0] filtered_value;
      logic                     run_end;
      logic                     short_input;
   } rsp_type;

   // Sequencer states.
   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_TAIL = 1'b1
   } seq_state_type;

   // Filter step issued by the sequencer to the cell row.
   typedef struct packed {
      logic issue;
      logic zero_in;
      logic final_step;
      logic short_input;
   } step_type;

   // Flags that travel down the pipeline next to the sums.
   typedef struct packed {
      logic valid;
      logic run_end;
      logic short_input;
   } ctl_type;

endpackage

/* rtl/fcu_cell.sv */
// ----------------------------------------------------------------------------
// FIR tap cell
// Holds one coefficient and one history sample, passes its sample to the
// next cell on every filter step and registers its masked product.
// ----------------------------------------------------------------------------
module fcu_cell import fcu_pkg::*; #(
   parameter int CELL_INDEX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       step,
   input  logic                       clear,
   input  logic                       coef_we,
   input  logic [TAP_INDEX_W-1:0]     coef_index,
   input  logic signed [COEF_W-1:0]   coef_value,
   input  logic                       tap_on,
   input  logic signed [SAMPLE_W-1:0] tap_in,
   output logic signed [SAMPLE_W-1:0] tap_out,
   output logic signed [FILT_W-1:0]   prod_out
);

   localparam int PROD_W = SAMPLE_W + COEF_W;

   logic signed [COEF_W-1:0]          coef_ff;
   logic signed [SAMPLE_W-1:0]        hold_ff;
   logic signed [SAMPLE_W-1:0]        hold_in;
   logic signed [FILT_W-1:0]          prod_ff;
   logic signed [FILT_W-1:0]          prod_in;
   logic signed [PROD_W-1:0]          prod_full;

   // Coefficient store for this tap.
   always_ff @(posedge clock) begin
      if (coef_we && (coef_index == TAP_INDEX_W'(CELL_INDEX))) begin
         coef_ff <= coef_value;
      end
   end

   // The history shifts on each step; the final step of a run empties it.
   always_comb begin
      hold_in = hold_ff;
      if (en && step) begin
         hold_in = clear ? '0 : tap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   // Product of this tap, zero when the tap lies beyond the taps in use.
   assign prod_full = PROD_W'(coef_ff) * PROD_W'(tap_in);
   assign prod_in   = tap_on ? FILT_W'(prod_full) : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign tap_out  = hold_ff;
   assign prod_out = prod_ff;

endmodule

/* rtl/fcu_sum_tree.sv */
// ----------------------------------------------------------------------------
// FIR adder tree
// Registered binary tree that sums the tap products, registered at each
// level, word flags delayed alongside. Sums wrap at the output width.
// ----------------------------------------------------------------------------
module fcu_sum_tree import fcu_pkg::*; #(
   parameter int LEAVES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic signed [FILT_W-1:0] leaf_in [LEAVES],
   input  ctl_type                  ctl_in,
   output logic signed [FILT_W-1:0] sum_out,
   output ctl_type                  ctl_out
);

   localparam int LEVELS = $clog2(LEAVES);
   localparam int NODES  = 2 ** LEVELS;

   logic signed [FILT_W-1:0] leaf    [NODES];
   logic signed [FILT_W-1:0] node_ff [1:NODES-1];
   logic signed [FILT_W-1:0] node_in [1:NODES-1];
   ctl_type                  ctl_ff  [LEVELS];

   // Pad the leaves up to a power of two.
   for (genvar i = 0; i < NODES; i++) begin : g_leaf
      if (i < LEAVES) begin : g_used
         assign leaf[i] = leaf_in[i];
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // Each node adds its two children; node 1 is the root.
   for (genvar i = 1; i < NODES; i++) begin : g_node
      if (2 * i >= NODES) begin : g_bottom
         assign node_in[i] = leaf[2*i-NODES] + leaf[2*i+1-NODES];
      end else begin : g_inner
         assign node_in[i] = node_ff[2*i] + node_ff[2*i+1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            node_ff[i] <= node_in[i];
         end
      end
   end

   // Flags follow the sums through the same number of levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LEVELS; k++) begin
            ctl_ff[k] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < LEVELS; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   assign sum_out = node_ff[1];
   assign ctl_out = ctl_ff[LEVELS-1];

endmodule

/* rtl/fcu_seq.sv */
// ----------------------------------------------------------------------------
// FIR step sequencer
// Accepts request words, issues one filter step per sample, and after the
// last sample issues the zero-input tail steps that finish the convolution.
// ----------------------------------------------------------------------------
module fcu_seq import fcu_pkg::*; #(
   parameter int MAX_TAPS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   req_valid,
   input  op_type                 req_op,
   input  logic                   req_last,
   input  logic [TAP_COUNT_W-1:0] taps_eff,
   output logic                   req_ready,
   output logic                   coef_we,
   output step_type               step
);

   seq_state_type          state_ff;
   seq_state_type          state_in;
   logic [TAP_COUNT_W-1:0] tail_ff;
   logic [TAP_COUNT_W-1:0] tail_in;
   logic [TAP_COUNT_W-1:0] seen_ff;
   logic [TAP_COUNT_W-1:0] seen_in;
   logic [TAP_COUNT_W-1:0] seen_next;
   logic                   short_ff;
   logic                   short_in;
   logic                   accept;
   logic                   sample_acc;
   logic                   short_now;

   assign accept     = req_valid && req_ready;
   assign sample_acc = accept && (req_op == OP_SAMPLE);

   // Sample count of the run, saturating at the tap capacity.
   assign seen_next = (seen_ff < TAP_COUNT_W'(MAX_TAPS)) ?
                      seen_ff + TAP_COUNT_W'(1) : seen_ff;
   assign short_now = seen_next < taps_eff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (sample_acc && req_last && (taps_eff > TAP_COUNT_W'(1))) begin
               state_in = SEQ_TAIL;
            end
         end
         SEQ_TAIL: begin
            if (en && (tail_ff == TAP_COUNT_W'(1))) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      coef_we   = 1'b0;
      step      = '0;
      case (state_ff)
         SEQ_IDLE: begin
            req_ready        = en;
            coef_we          = accept && (req_op == OP_COEF);
            step.issue       = sample_acc;
            step.final_step  = req_last && (taps_eff == TAP_COUNT_W'(1));
            step.short_input = short_now;
         end
         SEQ_TAIL: begin
            step.issue       = en;
            step.zero_in     = 1'b1;
            step.final_step  = tail_ff == TAP_COUNT_W'(1);
            step.short_input = short_ff;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Tail counter, run sample count and the short-run flag.
   always_comb begin
      tail_in  = tail_ff;
      seen_in  = seen_ff;
      short_in = short_ff;
      if (sample_acc) begin
         seen_in  = seen_next;
         short_in = short_now;
         tail_in  = taps_eff - TAP_COUNT_W'(1);
      end else if ((state_ff == SEQ_TAIL) && en) begin
         tail_in = tail_ff - TAP_COUNT_W'(1);
      end
      if (step.issue && step.final_step) begin
         seen_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         tail_ff  <= '0;
         seen_ff  <= '0;
         short_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tail_ff  <= tail_in;
         seen_ff  <= seen_in;
         short_ff <= short_in;
      end
   end

`ifndef NO_ASSERTIONS
   // No request word is taken while the tail is flushing.
   a_no_req_in_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_TAIL) |-> !req_ready)
      else $error("request accepted during tail flush");

   // A flushing tail always has steps left.
   a_tail_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_TAIL) |-> (tail_ff != '0))
      else $error("tail counter empty while flushing");

   // The final step of a run restarts the sample count.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (step.issue && step.final_step) |=> (seen_ff == '0))
      else $error("sample count not cleared after run end");
`endif

endmodule

/* rtl/fir_full_convolution_unit.sv */
// ----------------------------------------------------------------------------
// FIR full convolution unit
// Direct-form FIR filter giving the full linear convolution of a sample
// sequence with stored coefficients, as a row of tap cells feeding a
// registered adder tree.
//
//   Channel   Ports     Direction   Moves
//   request   req_*     in          coefficient write or sample word
//   response  rsp_*     out         one filtered word per filter step
//   config    csr_*     in/out      tap_count register at byte address 0
//
// A request word is taken each cycle while the response side keeps up.
// A filtered word passes one product stage in the cells and then the tree
// levels. After the last sample comes one zero-input flush step per tap in
// use beyond the first, during which no request is taken. A stalled
// response holds the whole pipeline.
// Reset is synchronous; it empties the history and needs no clearing pass.
// ----------------------------------------------------------------------------
module fir_full_convolution_unit import fcu_pkg::*; #(
   parameter int MAX_TAPS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TAP_COUNT_W-1:0]     tap_count_ff;
   logic [TAP_COUNT_W-1:0]     tap_count_in;
   logic [TAP_COUNT_W-1:0]     taps_eff;
   logic                       csr_wr;
   logic                       en;
   logic                       coef_we;
   step_type                   step;
   logic signed [SAMPLE_W-1:0] x_in;
   logic signed [SAMPLE_W-1:0] tap [MAX_TAPS];
   logic signed [FILT_W-1:0]   prod [MAX_TAPS];
   ctl_type                    ctl_ff;
   ctl_type                    ctl_in;
   ctl_type                    ctl_out;
   logic signed [FILT_W-1:0]   sum;

   // Configuration port: one register, always ready.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tap_count_in = tap_count_ff;
      if (csr_wr && (csr_paddr[2] == REG_TAP_COUNT)) begin
         tap_count_in = csr_pwdata[TAP_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_W'(1);
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TAP_COUNT) ? CSR_DATA_W'(tap_count_ff) : '0;

   // Taps in use: zero counts as one, large values stop at the capacity.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps_eff = TAP_COUNT_W'(1);
      end else if (tap_count_ff > TAP_COUNT_W'(MAX_TAPS)) begin
         taps_eff = TAP_COUNT_W'(MAX_TAPS);
      end else begin
         taps_eff = tap_count_ff;
      end
   end

   // The pipeline advances unless a finished word waits to be taken.
   assign en = !ctl_out.valid || rsp_ready;

   fcu_seq #(
      .MAX_TAPS (MAX_TAPS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_last  (req_data.last_sample),
      .taps_eff  (taps_eff),
      .req_ready (req_ready),
      .coef_we   (coef_we),
      .step      (step)
   );

   // Tail steps feed zeros into the row.
   assign x_in   = step.zero_in ? '0 : req_data.sample_value;
   assign tap[0] = x_in;

   // Row of tap cells, each but the last passing its history sample to the next.
   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      logic tap_on;
      assign tap_on = TAP_COUNT_W'(j) < taps_eff;

      if (j < MAX_TAPS - 1) begin : g_mid
         fcu_cell #(
            .CELL_INDEX (j)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .en         (en),
            .step       (step.issue),
            .clear      (step.final_step),
            .coef_we    (coef_we),
            .coef_index (req_data.tap_index),
            .coef_value (req_data.coef_value),
            .tap_on     (tap_on),
            .tap_in     (tap[j]),
            .tap_out    (tap[j+1]),
            .prod_out   (prod[j])
         );
      end else begin : g_end
         fcu_cell #(
            .CELL_INDEX (j)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .en         (en),
            .step       (step.issue),
            .clear      (step.final_step),
            .coef_we    (coef_we),
            .coef_index (req_data.tap_index),
            .coef_value (req_data.coef_value),
            .tap_on     (tap_on),
            .tap_in     (tap[j]),
            .tap_out    (),
            .prod_out   (prod[j])
         );
      end
   end

   // Word flags for the product stage.
   always_comb begin
      ctl_in.valid       = step.issue;
      ctl_in.run_end     = step.issue && step.final_step;
      ctl_in.short_input = step.issue && step.final_step && step.short_input;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   fcu_sum_tree #(
      .LEAVES (MAX_TAPS)
   ) u_tree (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .leaf_in (prod),
      .ctl_in  (ctl_ff),
      .sum_out (sum),
      .ctl_out (ctl_out)
   );

   // Response word.
   assign rsp_valid               = ctl_out.valid;
   assign rsp_data.filtered_value = sum;
   assign rsp_data.run_end        = ctl_out.run_end;
   assign rsp_data.short_input    = ctl_out.short_input;

`ifndef NO_ASSERTIONS
   // A coefficient write and a filter step never share a cycle.
   a_coef_step_excl: assert property (@(posedge clock) disable iff (reset)
      !(coef_we && step.issue))
      else $error("coefficient write during a filter step");

   // The short-run flag only rides on the final word of a run.
   a_short_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.short_input) |-> rsp_data.run_end)
      else $error("short_input without run_end");

   // No request is taken while a finished word is stalled.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while the response stalls");
`endif

endmodule
